// File: hw/rtl/fixed_frame_deframer_macros.svh
// Assertion macros shared by the fixed frame deframer RTL.
// Depends on nothing; the asserting modules provide clock and reset signals.
`ifndef FIXED_FRAME_DEFRAMER_MACROS_SVH
`define FIXED_FRAME_DEFRAMER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Property checked on every clock edge outside reset.
`define FFD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("fixed_frame_deframer assertion failed");
// Property checked on every clock edge, reset included.
`define FFD_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("fixed_frame_deframer reset assertion failed");
`else
`define FFD_ASSERT(label, prop)
`define FFD_ASSERT_RST(label, prop)
`endif

`endif

// File: hw/rtl/ffd_pkg.sv
// Package for the fixed frame deframer: frame layout constants and result type.
// Used by the parser, the result register and the top module; depends on nothing.
package ffd_pkg;

   // Frame layout.
   localparam int FRAME_BYTES = 256;
   localparam int MAX_PAYLOAD = 247;

   localparam logic [7:0] POS_LAST      = 8'(FRAME_BYTES - 1);
   localparam logic [7:0] PAYLOAD_START = 8'd3;
   localparam logic [7:0] CKSUM_POS     = 8'(FRAME_BYTES - 6);
   localparam logic [7:0] STAMP_POS     = 8'(FRAME_BYTES - 4);
   localparam logic [7:0] STAMP_BYTES   = 8'd4;
   localparam logic [7:0] MAX_PAYLOAD_IDX = 8'(MAX_PAYLOAD);
   localparam logic [15:0] MAX_PAYLOAD_LEN = 16'(MAX_PAYLOAD);

   // Reset value of the checksum span register.
   localparam logic [7:0] SPAN_RESET = 8'd244;

   // Width of the packed result data word on the output bus.
   localparam int RSP_DATA_BITS = 80;

   // One result word: a payload byte or an end-of-frame summary.
   typedef struct packed {
      logic        length_error;
      logic        checksum_ok;
      logic [31:0] timestamp;
      logic [15:0] payload_len;
      logic [7:0]  msg_type;
      logic [7:0]  data_index;
      logic [7:0]  data_byte;
      logic        is_frame_end;
   } rsp_type;

endpackage

// File: hw/rtl/ffd_in_reg.sv
// Input register stage of the fixed frame deframer.
// Holds one received byte until the parser takes it; uses no package items.
module ffd_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       take,
   output logic       in_valid,
   output logic [7:0] in_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   // The stage is free when empty or when its word leaves in this cycle.
   assign req_tready = !valid_ff || take;

   // Next state of the holding register.
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
         byte_in  = req_tdata;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

// File: hw/rtl/ffd_parser.sv
// Frame parser of the fixed frame deframer: position counter, header and
// tail capture, running checksum and result forming. Depends on ffd_pkg.
`include "fixed_frame_deframer_macros.svh"
module ffd_parser (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [7:0]      csr_wr_data,
   input  logic            in_valid,
   input  logic [7:0]      in_byte,
   input  logic            out_ready,
   output logic            take,
   output logic            res_load,
   output ffd_pkg::rsp_type res
);

   logic [7:0]  span_ff;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] sum_ff, sum_in, sum_new;
   logic [15:0] cksum_ff, cksum_in;
   logic [31:0] stamp_ff, stamp_in;
   logic [7:0]  stamp_lane;
   logic [7:0]  payload_idx;
   logic        len_err;
   logic        res_valid;

   // A byte moves on when it is present and the result register has room.
   assign take     = in_valid && out_ready;
   assign res_load = take && res_valid;

   assign stamp_lane  = pos_ff - ffd_pkg::STAMP_POS;
   assign payload_idx = pos_ff - ffd_pkg::PAYLOAD_START;

   // Field capture, checksum and result for the byte at the current position.
   always_comb begin
      sum_new   = sum_ff;
      type_in   = type_ff;
      length_in = length_ff;
      cksum_in  = cksum_ff;
      stamp_in  = stamp_ff;
      res       = '0;
      res_valid = 1'b0;

      if (pos_ff < span_ff) begin
         sum_new = sum_ff + 16'(in_byte);
      end
      if (pos_ff == 8'd0) begin
         type_in = in_byte;
      end
      if (pos_ff == 8'd1) begin
         length_in[7:0] = in_byte;
      end
      if (pos_ff == 8'd2) begin
         length_in[15:8] = in_byte;
      end
      if (pos_ff == ffd_pkg::CKSUM_POS) begin
         cksum_in[7:0] = in_byte;
      end
      if (pos_ff == ffd_pkg::CKSUM_POS + 8'd1) begin
         cksum_in[15:8] = in_byte;
      end
      if (pos_ff >= ffd_pkg::STAMP_POS && stamp_lane < ffd_pkg::STAMP_BYTES) begin
         stamp_in[stamp_lane[1:0]*8 +: 8] = in_byte;
      end

      len_err = length_in > ffd_pkg::MAX_PAYLOAD_LEN;
      sum_in  = sum_new;
      pos_in  = pos_ff + 8'd1;

      if (pos_ff == ffd_pkg::POS_LAST) begin
         // End of frame: summary word, then start the next frame afresh.
         res.is_frame_end = 1'b1;
         res.msg_type     = type_in;
         res.payload_len  = length_in;
         res.timestamp    = stamp_in;
         res.checksum_ok  = (cksum_in == sum_new);
         res.length_error = len_err;
         res_valid        = 1'b1;
         sum_in           = '0;
         pos_in           = '0;
      end else if (pos_ff >= ffd_pkg::PAYLOAD_START && pos_ff < ffd_pkg::CKSUM_POS
                   && !len_err) begin
         // Payload byte within the announced length.
         if (payload_idx < ffd_pkg::MAX_PAYLOAD_IDX && 16'(payload_idx) < length_in) begin
            res.data_byte  = in_byte;
            res.data_index = payload_idx;
            res_valid      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff   <= ffd_pkg::SPAN_RESET;
         pos_ff    <= '0;
         type_ff   <= '0;
         length_ff <= '0;
         sum_ff    <= '0;
         cksum_ff  <= '0;
         stamp_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            span_ff <= csr_wr_data;
         end
         if (take) begin
            pos_ff    <= pos_in;
            type_ff   <= type_in;
            length_ff <= length_in;
            sum_ff    <= sum_in;
            cksum_ff  <= cksum_in;
            stamp_ff  <= stamp_in;
         end
      end
   end

   // The last byte of a frame always sends the position back to the start.
   `FFD_ASSERT(a_pos_wraps, (take && pos_ff == ffd_pkg::POS_LAST) |=> (pos_ff == 8'd0))
   // A summary word is produced only at the last frame position.
   `FFD_ASSERT(a_summary_at_end, (res_load && res.is_frame_end) |-> (pos_ff == ffd_pkg::POS_LAST))
   // Payload words stay inside the payload area and never carry a length error.
   `FFD_ASSERT(a_payload_range,
      (res_load && !res.is_frame_end) |-> (res.data_index < ffd_pkg::MAX_PAYLOAD_IDX && !len_err))

endmodule

// File: hw/rtl/ffd_out_reg.sv
// Result register of the fixed frame deframer: holds one word for the output bus.
// Depends on ffd_pkg for the result type.
module ffd_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  ffd_pkg::rsp_type res,
   output logic             out_ready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output ffd_pkg::rsp_type rsp_word
);

   logic             valid_ff, valid_in;
   ffd_pkg::rsp_type word_ff, word_in;

   // Room when empty or when the held word is taken in this cycle.
   assign out_ready = !valid_ff || rsp_tready;

   // Next state of the result register.
   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (load) begin
         valid_in = 1'b1;
         word_in  = res;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_word   = word_ff;

endmodule

// File: hw/rtl/fixed_frame_deframer.sv
// Fixed frame deframer: one received byte per cycle while the output is not stalled,
// 256-byte frames. A byte waits in the input register until the parser takes it and
// loads its word, if any, into the result register; the parser forms it combinationally.
// Synchronous reset empties both registers, sets the frame position to zero,
// clears the captured fields and loads the checksum span with 244.
`include "fixed_frame_deframer_macros.svh"
module fixed_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   // Checksum span register write.
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   // Received bytes.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // Result words.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] data_byte, [15:8] data_index, [23:16] msg_type, [39:24] payload_len,
   // [71:40] timestamp, [72] checksum_ok, [73] length_error, [79:74] zero
   output logic [ffd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic        rsp_tuser    // is_frame_end
);

   logic             in_valid;
   logic [7:0]       in_byte;
   logic             take;
   logic             res_load;
   logic             out_ready;
   ffd_pkg::rsp_type res;
   ffd_pkg::rsp_type rsp_word;

   ffd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .in_valid   (in_valid),
      .in_byte    (in_byte)
   );

   ffd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (in_valid),
      .in_byte     (in_byte),
      .out_ready   (out_ready),
      .take        (take),
      .res_load    (res_load),
      .res         (res)
   );

   ffd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (res_load),
      .res        (res),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   // Pack the result word onto the output bus.
   assign rsp_tuser = rsp_word.is_frame_end;
   assign rsp_tdata = {6'd0,
                       rsp_word.length_error,
                       rsp_word.checksum_ok,
                       rsp_word.timestamp,
                       rsp_word.payload_len,
                       rsp_word.msg_type,
                       rsp_word.data_index,
                       rsp_word.data_byte};

   // No result word is offered in the cycle after a reset.
   `FFD_ASSERT_RST(a_reset_empty, reset |=> !rsp_tvalid)

endmodule

// File: sim/fixed_frame_deframer_tb.sv
// Self-checking bench for the fixed frame deframer: sends 256-byte frames and a partial
// frame, and checks every payload word and end-of-frame summary against a scoreboard prediction.
// Depends on ffd_pkg and the fixed_frame_deframer RTL only.
module fixed_frame_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PARTIAL_BYTES = 82;

   // Checksum handling of a built frame.
   localparam int SUM_SEALED = 0;
   localparam int SUM_SKEWED = 1;
   localparam int SUM_RAW    = 2;

   // Scoreboard: tracks the frame parser state and holds the expected words.
   class frame_tracker;
      logic [7:0]       span;
      logic [7:0]       position;
      logic [7:0]       kind;
      logic [15:0]      length;
      logic [15:0]      running_sum;
      logic [15:0]      sent_sum;
      logic [31:0]      stamp;
      ffd_pkg::rsp_type pending[$];
      int               mismatches;

      function new();
         span        = ffd_pkg::SPAN_RESET;
         position    = '0;
         kind        = '0;
         length      = '0;
         running_sum = '0;
         sent_sum    = '0;
         stamp       = '0;
         mismatches  = 0;
      endfunction

      // Update the parser state with one accepted byte and queue any word it causes.
      function void take_byte(logic [7:0] b);
         ffd_pkg::rsp_type word;
         logic [7:0]       slot;
         logic             too_long;
         slot = position;
         if (slot < span) begin
            running_sum = running_sum + 16'(b);
         end
         if (slot == 8'd0) kind = b;
         if (slot == 8'd1) length[7:0] = b;
         if (slot == 8'd2) length[15:8] = b;
         if (slot == ffd_pkg::CKSUM_POS) sent_sum[7:0] = b;
         if (slot == ffd_pkg::CKSUM_POS + 8'd1) sent_sum[15:8] = b;
         if (slot >= ffd_pkg::STAMP_POS && slot - ffd_pkg::STAMP_POS < ffd_pkg::STAMP_BYTES) begin
            stamp[8 * (slot - ffd_pkg::STAMP_POS) +: 8] = b;
         end
         too_long = length > ffd_pkg::MAX_PAYLOAD_LEN;
         word = '0;
         if (slot == ffd_pkg::POS_LAST) begin
            word.is_frame_end = 1'b1;
            word.msg_type     = kind;
            word.payload_len  = length;
            word.timestamp    = stamp;
            word.checksum_ok  = sent_sum == running_sum;
            word.length_error = too_long;
            pending.push_back(word);
            running_sum = '0;
            position    = '0;
         end else begin
            // Payload bytes pass only inside the stated length and before the checksum.
            if (slot >= ffd_pkg::PAYLOAD_START && slot < ffd_pkg::CKSUM_POS && !too_long &&
                slot - ffd_pkg::PAYLOAD_START < ffd_pkg::MAX_PAYLOAD_IDX &&
                16'(slot - ffd_pkg::PAYLOAD_START) < length) begin
               word.data_byte  = b;
               word.data_index = slot - ffd_pkg::PAYLOAD_START;
               pending.push_back(word);
            end
            position = slot + 8'd1;
         end
      endfunction

      function void check_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
         end
      endfunction

      // Compare one accepted result word with the oldest expectation.
      function void check_word(logic last_flag, logic [79:0] data);
         ffd_pkg::rsp_type got;
         ffd_pkg::rsp_type want;
         got = {data[73:0], last_flag};
         if (pending.size() == 0) begin
            $error("unexpected word: tuser=%0b tdata=0x%h", last_flag, data);
            mismatches++;
            return;
         end
         want = pending.pop_front();
         check_field("is_frame_end", want.is_frame_end, got.is_frame_end);
         check_field("data_byte", want.data_byte, got.data_byte);
         check_field("data_index", want.data_index, got.data_index);
         check_field("msg_type", want.msg_type, got.msg_type);
         check_field("payload_len", want.payload_len, got.payload_len);
         check_field("timestamp", want.timestamp, got.timestamp);
         check_field("checksum_ok", want.checksum_ok, got.checksum_ok);
         check_field("length_error", want.length_error, got.length_error);
         check_field("tdata padding", 32'd0, data[79:74]);
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [7:0]  csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;

   frame_tracker tracker = new();
   logic [7:0]   frame_buf [0:ffd_pkg::FRAME_BYTES-1];
   int           frames_sent    = 0;
   int           send_gap_pct   = 7;
   int           recv_stall_pct = 61;
   int           cycle_count    = 0;

   fixed_frame_deframer dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Receiver side: random back-pressure at the rate of the current phase.
   always @(posedge clock) begin
      rsp_tready <= $urandom_range(99) >= recv_stall_pct;
   end

   // Watch both channels; results are checked before the byte of the same edge is noted.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) tracker.check_word(rsp_tuser, rsp_tdata);
         if (req_tvalid && req_tready) tracker.take_byte(req_tdata);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Send one byte; each cycle in front of it idles with the current gap rate.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending and wait until every expected word has come out.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_span(input logic [7:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tracker.span = value;
   endtask

   // Build a frame with random filler and send its first count bytes;
   // the idle phase follows the frame count.
   task automatic run_frame(input logic [7:0] kind, input logic [15:0] length,
                            input logic [31:0] stamp, input int mode, input int count);
      logic [15:0] sum;
      if (frames_sent == 0) begin
         send_gap_pct   = 7;
         recv_stall_pct = 61;
      end else if (frames_sent == 1) begin
         send_gap_pct   = 61;
         recv_stall_pct = 7;
      end else begin
         send_gap_pct   = 0;
         recv_stall_pct = 0;
      end
      for (int i = 0; i < ffd_pkg::FRAME_BYTES; i++) frame_buf[i] = 8'($urandom);
      frame_buf[0] = kind;
      frame_buf[1] = length[7:0];
      frame_buf[2] = length[15:8];
      // A full payload carries both byte extremes.
      if (length == ffd_pkg::MAX_PAYLOAD_LEN) begin
         frame_buf[ffd_pkg::PAYLOAD_START]        = 8'h00;
         frame_buf[ffd_pkg::PAYLOAD_START + 8'd1] = 8'hFF;
      end
      for (int k = 0; k < ffd_pkg::STAMP_BYTES; k++) begin
         frame_buf[ffd_pkg::STAMP_POS + k] = stamp[8 * k +: 8];
      end
      if (mode != SUM_RAW) begin
         sum = '0;
         for (int i = 0; i < tracker.span && i < ffd_pkg::CKSUM_POS; i++) begin
            sum = sum + 16'(frame_buf[i]);
         end
         if (mode == SUM_SKEWED) sum = sum + 16'd1;
         frame_buf[ffd_pkg::CKSUM_POS]        = sum[7:0];
         frame_buf[ffd_pkg::CKSUM_POS + 8'd1] = sum[15:8];
      end
      for (int i = 0; i < count; i++) send_byte(frame_buf[i]);
      frames_sent++;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Full payload with byte extremes under the reset span.
      run_frame(8'hFF, ffd_pkg::MAX_PAYLOAD_LEN, 32'hFFFF_FFFF, SUM_SEALED,
                ffd_pkg::FRAME_BYTES);
      // Span up to the checksum, length just over the limit, bad checksum.
      write_span(8'd250);
      run_frame(8'h5A, ffd_pkg::MAX_PAYLOAD_LEN + 16'd1, $urandom, SUM_SKEWED,
                ffd_pkg::FRAME_BYTES);
      // Empty span and empty payload.
      write_span(8'd0);
      run_frame(8'h00, 16'd0, 32'h0000_0000, SUM_SEALED, ffd_pkg::FRAME_BYTES);
      // Span past the checksum and the start of one more frame with random length.
      write_span(8'd255);
      run_frame(8'($urandom), 16'($urandom_range(1, 246)), $urandom, SUM_RAW,
                PARTIAL_BYTES);

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
